// ===== hw/rtl/lph_pkg.sv =====
package lph_pkg;

  localparam int unsigned DEPTH_DEF = 4096;
  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned BC_W = 13;
  localparam int unsigned SIDX_W = 12;
  localparam int unsigned MISS_W = 13;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_FULL = 2'd1;
  localparam logic [1:0] MARK_TOMB = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request, start home multiply
    logic home;      // take home slot into probe pointer
    logic rd;        // issue slot read at probe pointer
    logic step;      // advance pointer, count a miss
    logic wr_ins;    // write full slot with key and value
    logic wr_tomb;   // mark slot tombstone
    logic clr;       // clearing pass write
    logic fin;       // load result register
    logic [1:0] st;  // result status
    logic with_idx;  // report slot index
    logic with_val;  // report value
  } lph_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] mark;
    logic key_eq;
    logic cap_hit;   // probe has examined bucket_count slots
    logic full_tbl;  // record_count >= bucket_count
    logic clr_last;
  } lph_sts_t;

endpackage

// ===== hw/rtl/lph_datapath.sv =====
module lph_datapath #(
  parameter int unsigned TABLE_DEPTH = lph_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic [lph_pkg::BC_W-1:0] bucket_count_r,
  input  logic [1:0] in_cmd,
  input  logic [lph_pkg::KEY_W-1:0] in_lookup_key,
  input  logic [lph_pkg::VAL_W-1:0] in_value_in,
  input  lph_pkg::lph_cmd_t cmd,
  output lph_pkg::lph_sts_t sts,
  output logic [1:0] res_status,
  output logic [lph_pkg::VAL_W-1:0] res_value,
  output logic [lph_pkg::SIDX_W-1:0] res_slot,
  output logic [lph_pkg::MISS_W-1:0] res_miss
);
  import lph_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (NW > 32) ? NW : 32;

  logic [1:0] mark_mem [TABLE_DEPTH];
  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [VAL_W-1:0] val_mem [TABLE_DEPTH];

  logic [1:0] cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [NW-1:0] n_r;
  logic [KEY_W+NW-1:0] prod_r;
  logic [AW-1:0] ptr_r;
  logic [NW-1:0] cnt_r;
  logic [NW-1:0] recs_r, recs_nxt;
  logic [NW-1:0] tombs_r, tombs_nxt;
  logic [AW-1:0] clr_r;
  logic [1:0] mark_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [NW-1:0] n_eff;
  logic [CW-1:0] bc_wide;

  // clamp bucket count to 1..depth
  always_comb begin
    bc_wide = CW'(bucket_count_r);
    if (bucket_count_r == '0) n_eff = NW'(1);
    else if (bc_wide > CW'(TABLE_DEPTH)) n_eff = NW'(TABLE_DEPTH);
    else n_eff = NW'(bucket_count_r);
  end

  // request capture and home multiply
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= in_cmd;
      key_r <= in_lookup_key;
      val_r <= in_value_in;
      n_r <= n_eff;
      prod_r <= (KEY_W+NW)'(in_lookup_key) * (KEY_W+NW)'(n_eff);
    end
  end

  // probe pointer and examined count
  always_ff @(posedge clk) begin
    if (cmd.home) begin
      ptr_r <= AW'(prod_r[KEY_W +: NW]);
      cnt_r <= '0;
    end else if (cmd.step) begin
      cnt_r <= cnt_r + NW'(1);
      if (NW'(ptr_r) + NW'(1) >= n_r) ptr_r <= '0;
      else ptr_r <= ptr_r + AW'(1);
    end
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (cmd.clr) mark_mem[clr_r] <= MARK_EMPTY;
    else if (cmd.wr_ins) mark_mem[ptr_r] <= MARK_FULL;
    else if (cmd.wr_tomb) mark_mem[ptr_r] <= MARK_TOMB;
    if (cmd.rd) mark_q <= mark_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_ins) begin
      key_mem[ptr_r] <= key_r;
      val_mem[ptr_r] <= val_r;
    end
    if (cmd.rd) begin
      key_q <= key_mem[ptr_r];
      val_q <= val_mem[ptr_r];
    end
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr) clr_r <= clr_r + AW'(1);
  end

  // record and tombstone counts
  always_comb begin
    recs_nxt = recs_r;
    tombs_nxt = tombs_r;
    if (cmd.wr_ins) begin
      recs_nxt = recs_r + NW'(1);
      if (mark_q == MARK_TOMB && tombs_r != '0) tombs_nxt = tombs_r - NW'(1);
    end else if (cmd.wr_tomb) begin
      tombs_nxt = tombs_r + NW'(1);
      if (recs_r != '0) recs_nxt = recs_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recs_r <= '0;
      tombs_r <= '0;
    end else begin
      recs_r <= recs_nxt;
      tombs_r <= tombs_nxt;
    end
  end

  // result register, no probe taken on an early answer
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_status <= cmd.st;
      res_value <= cmd.with_val ? val_q : '0;
      res_slot <= cmd.with_idx ? SIDX_W'(ptr_r) : '0;
      res_miss <= cmd.home ? '0 : MISS_W'(cnt_r);
    end
  end

  assign sts.cmd = cmd_r;
  assign sts.mark = mark_q;
  assign sts.key_eq = (key_q == key_r);
  assign sts.cap_hit = (cnt_r >= n_r);
  assign sts.full_tbl = (recs_r >= n_r);
  assign sts.clr_last = (clr_r == AW'(TABLE_DEPTH - 1));

  // record count stays within the table
  assert property (@(posedge clk) disable iff (!rst_n) recs_r <= NW'(TABLE_DEPTH))
    else $error("record count exceeds depth");
  // probe pointer stays inside active slots
  assert property (@(posedge clk) disable iff (!rst_n) cmd.rd |-> NW'(ptr_r) < n_r)
    else $error("probe outside bucket range");
  // insert and tombstone writes never coincide
  assert property (@(posedge clk) disable iff (!rst_n) !(cmd.wr_ins && cmd.wr_tomb))
    else $error("conflicting slot writes");

endmodule

// ===== hw/rtl/lph_ctrl.sv =====
module lph_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  lph_pkg::lph_sts_t sts,
  output lph_pkg::lph_cmd_t cmd
);
  import lph_pkg::*;

  localparam logic [2:0] S_CLR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MUL = 3'd2;
  localparam logic [2:0] S_RD = 3'd3;
  localparam logic [2:0] S_EVAL = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        cmd.load = accept;
        if (accept) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.home = 1'b1;
        state_nxt = S_RD;
        if (sts.cmd == CMD_INSERT && sts.full_tbl) begin
          cmd.fin = 1'b1;
          cmd.st = ST_FULL;
          state_nxt = S_OUT;
        end else if (sts.cmd != CMD_INSERT && sts.cmd != CMD_QUERY &&
                     sts.cmd != CMD_REMOVE) begin
          cmd.fin = 1'b1;
          cmd.st = ST_MISS;
          state_nxt = S_OUT;
        end
      end
      S_RD: begin
        if (sts.cap_hit) begin
          cmd.fin = 1'b1;
          cmd.st = (sts.cmd == CMD_INSERT) ? ST_FULL : ST_MISS;
          state_nxt = S_OUT;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_RD;
        if (sts.cmd == CMD_INSERT) begin
          if (sts.mark != MARK_FULL) begin
            cmd.wr_ins = 1'b1;
            cmd.fin = 1'b1;
            cmd.st = ST_OK;
            cmd.with_idx = 1'b1;
            state_nxt = S_OUT;
          end else if (sts.key_eq) begin
            cmd.fin = 1'b1;
            cmd.st = ST_DUP;
            state_nxt = S_OUT;
          end else begin
            cmd.step = 1'b1;
          end
        end else begin
          if (sts.mark == MARK_FULL && sts.key_eq) begin
            cmd.fin = 1'b1;
            cmd.st = ST_OK;
            cmd.with_idx = 1'b1;
            cmd.with_val = (sts.cmd == CMD_QUERY);
            cmd.wr_tomb = (sts.cmd == CMD_REMOVE);
            state_nxt = S_OUT;
          end else if (sts.mark == MARK_EMPTY) begin
            cmd.fin = 1'b1;
            cmd.st = ST_MISS;
            state_nxt = S_OUT;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // no request taken during clearing pass
  assert property (@(posedge clk) disable iff (!rst_n) state_r == S_CLR |-> !in_ready)
    else $error("request accepted while clearing");
  // result loaded only while output register is free or draining
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT |-> !out_valid_r || out_ready)
    else $error("result overwrite");
  // an accepted request moves the sequencer into S_MUL
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> state_r == S_MUL)
    else $error("request lost");

endmodule

// ===== hw/rtl/linear_probe_hash_table_core.sv =====
// Open-addressed hash table with linear probing and tombstones.
// Input channel in_valid/in_ready carries one request: in_cmd (0 insert,
// 1 query, 2 remove), in_lookup_key and in_value_in. The result channel
// out_valid/out_ready returns out_status, out_value_out, out_slot_index and
// out_probe_misses, one result per request, in order.
// cfg_valid/cfg_ready writes bucket_count (cfg_bucket_count); write it only
// while the block is idle. It is clamped to 1..TABLE_DEPTH.
// Each accepted request passes S_MUL, then S_RD and S_EVAL for each slot
// examined (the slot memory read is registered), then S_OUT; a probe that
// runs out of slots ends from S_RD, and a full-table insert or an unknown
// request is answered from S_MUL. One request is in flight at a time.
// After reset a clearing pass writes every slot empty, during which in_ready
// is low; configuration writes are taken throughout.
// The result sits in an output register; when the receiver stalls it is
// held there and in_ready stays low until it is taken.
module linear_probe_hash_table_core #(
  parameter int unsigned TABLE_DEPTH = lph_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [lph_pkg::BC_W-1:0] cfg_bucket_count,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_cmd,
  input  logic [lph_pkg::KEY_W-1:0] in_lookup_key,
  input  logic [lph_pkg::VAL_W-1:0] in_value_in,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_status,
  output logic [lph_pkg::VAL_W-1:0] out_value_out,
  output logic [lph_pkg::SIDX_W-1:0] out_slot_index,
  output logic [lph_pkg::MISS_W-1:0] out_probe_misses
);
  import lph_pkg::*;

  logic [BC_W-1:0] bucket_count_r;
  lph_cmd_t cmd;
  lph_sts_t sts;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) bucket_count_r <= BC_W'(4096);
    else if (cfg_valid) bucket_count_r <= cfg_bucket_count;
  end

  lph_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  lph_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .bucket_count_r(bucket_count_r),
    .in_cmd(in_cmd), .in_lookup_key(in_lookup_key), .in_value_in(in_value_in),
    .cmd(cmd), .sts(sts), .res_status(out_status), .res_value(out_value_out),
    .res_slot(out_slot_index), .res_miss(out_probe_misses)
  );

endmodule
